>>> rtl/rlpd_pkg.sv
// Shared types and constants for the run-length palette pixel decoder.
`default_nettype none
package rlpd_pkg;

  // Frame geometry limit
  localparam int MAX_DIM = 256;
  localparam int PIX_W = 17;
  localparam logic [PIX_W-1:0] MAX_PIXELS = PIX_W'(MAX_DIM * MAX_DIM);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int COLOR_W = 16;
  localparam int LEN_W = 8;
  localparam int PAL_IDX_W = 4;
  localparam int PAL_WORD_W = 64;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_WORD3 = 3'd4;

  // Token byte fields
  localparam int TOKEN_REPEAT_BIT = 7;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    PH_TOKEN   = 2'd0,
    PH_COLOR   = 2'd1,
    PH_LITERAL = 2'd2,
    PH_FULL    = 2'd3
  } phase_t;

endpackage
`default_nettype wire

>>> rtl/rlpd_config_regs.sv
// Configuration registers: frame size with clamping and the 16-entry palette lookup.
`default_nettype none
module rlpd_config_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rlpd_pkg::cfg_wr_t              cfg,
  input  wire logic [rlpd_pkg::PAL_IDX_W-1:0] color_index,
  output logic      [rlpd_pkg::COLOR_W-1:0]   pal_color,
  output logic      [rlpd_pkg::PIX_W-1:0]     frame_limit
);
  import rlpd_pkg::*;

  logic [PIX_W-1:0] frame_pixels;
  logic [3:0][PAL_WORD_W-1:0] palette;

  // Write one register per enabled cycle; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= PIX_W'(1);
      palette <= '0;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_FRAME_PIXELS:  frame_pixels <= cfg.data[PIX_W-1:0];
        REG_PALETTE_WORD0: palette[0] <= cfg.data;
        REG_PALETTE_WORD1: palette[1] <= cfg.data;
        REG_PALETTE_WORD2: palette[2] <= cfg.data;
        REG_PALETTE_WORD3: palette[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero counts as one, cap at the largest frame
  always_comb begin
    if (frame_pixels == '0) begin
      frame_limit = PIX_W'(1);
    end else if (frame_pixels > MAX_PIXELS) begin
      frame_limit = MAX_PIXELS;
    end else begin
      frame_limit = frame_pixels;
    end
  end

  // Select the 16-bit entry within its 64-bit word
  assign pal_color = palette[color_index[3:2]][{color_index[1:0], 4'b0000} +: COLOR_W];

endmodule
`default_nettype wire

>>> rtl/rle_palette_pixel_decoder.sv
// An accepted input item that produces a result is loaded straight into the output register.
// The block takes one input item per cycle, and the output register refills as it drains.
// Input is held off only while the output register is full and not being taken.
// Reset (synchronous, active high) clears the decode state, frame_pixels to 1, palette to 0.
// The last byte of a stream returns the decode state to reset; registers keep their values.
`default_nettype none
module rle_palette_pixel_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  wire logic                            s_tlast,   // last_byte
  // Result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [23:0]                     m_tdata,   // [15:0] pixel_color, [23:16] run_length
  output logic                                 m_tlast,   // frame_full
  output logic      [0:0]                      m_tuser,   // [0] stream_short
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [rlpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlpd_pkg::*;

  cfg_wr_t cfg;
  logic [COLOR_W-1:0] pal_color;
  logic [PIX_W-1:0] frame_limit;

  phase_t phase, phase_next;
  logic [LEN_W-1:0] literal_left, literal_left_next;
  logic [LEN_W-1:0] repeat_len, repeat_len_next;
  logic [PIX_W-1:0] pixels_remaining, pixels_remaining_next;

  logic s_accept;
  logic res_load;
  logic [COLOR_W-1:0] res_color;
  logic [LEN_W-1:0] res_len;
  logic res_full;
  logic res_short;

  logic emit;
  logic [LEN_W-1:0] run_len;
  logic [PIX_W-1:0] pix_after;
  logic run_full;
  logic [BYTE_W-1:0] data_byte;

  logic out_valid;
  logic [COLOR_W-1:0] out_color;
  logic [LEN_W-1:0] out_len;
  logic out_full;
  logic out_short;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign data_byte = s_tdata;

  rlpd_config_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .color_index (data_byte[PAL_IDX_W-1:0]),
    .pal_color   (pal_color),
    .frame_limit (frame_limit)
  );

  // Take a new item whenever the output register is empty or draining
  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // Decode one byte: next state and the result it causes
  always_comb begin
    phase_next = phase;
    literal_left_next = literal_left;
    repeat_len_next = repeat_len;
    pixels_remaining_next = pixels_remaining;
    emit = 1'b0;
    run_len = '0;
    pix_after = pixels_remaining;
    run_full = 1'b0;

    unique case (phase)
      PH_TOKEN: begin
        if (pixels_remaining == '0) begin
          pixels_remaining_next = frame_limit;
        end
        if (data_byte[TOKEN_REPEAT_BIT]) begin
          repeat_len_next = {1'b0, data_byte[TOKEN_REPEAT_BIT-1:0]} + LEN_W'(1);
          phase_next = PH_COLOR;
        end else begin
          literal_left_next = data_byte + LEN_W'(1);
          phase_next = PH_LITERAL;
        end
      end
      PH_COLOR: begin
        if (PIX_W'(repeat_len) > pixels_remaining) begin
          run_len = pixels_remaining[LEN_W-1:0];
        end else begin
          run_len = repeat_len;
        end
        pix_after = pixels_remaining - PIX_W'(run_len);
        run_full = (pix_after == '0);
        pixels_remaining_next = pix_after;
        emit = 1'b1;
        phase_next = run_full ? PH_FULL : PH_TOKEN;
      end
      PH_LITERAL: begin
        run_len = LEN_W'(1);
        pix_after = pixels_remaining - PIX_W'(1);
        run_full = (pix_after == '0);
        pixels_remaining_next = pix_after;
        if (literal_left != '0) begin
          literal_left_next = literal_left - LEN_W'(1);
        end
        emit = 1'b1;
        if (run_full) begin
          phase_next = PH_FULL;
        end else if (literal_left_next == '0) begin
          phase_next = PH_TOKEN;
        end
      end
      PH_FULL: ;
      default: ;
    endcase

    // Stream end: flag a short frame unless the frame is full, then drop back to the start state
    res_short = s_tlast && (phase_next != PH_FULL);
    res_load = emit || res_short;
    res_color = emit ? pal_color : '0;
    res_len = run_len;
    res_full = run_full && !res_short;
    if (s_tlast) begin
      phase_next = PH_TOKEN;
      literal_left_next = '0;
      repeat_len_next = '0;
      pixels_remaining_next = '0;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOKEN;
      literal_left <= '0;
      repeat_len <= '0;
      pixels_remaining <= '0;
    end else if (s_accept) begin
      phase <= phase_next;
      literal_left <= literal_left_next;
      repeat_len <= repeat_len_next;
      pixels_remaining <= pixels_remaining_next;
    end
  end

  // Output register: load a new result, or clear valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept && res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && res_load) begin
      out_color <= res_color;
      out_len <= res_len;
      out_full <= res_full;
      out_short <= res_short;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out_len, out_color};
  assign m_tlast = out_full;
  assign m_tuser = out_short;

endmodule
`default_nettype wire
